### rtl/dbcd_pkg.sv
// Shared types and constants for the BC1 color sub-block decoder.
// No dependencies; imported by every module of the decoder.
`timescale 1ns / 1ps
`default_nettype none
package dbcd_pkg;

   localparam int PixelCount = 16;
   localparam int PixelBits  = $clog2(PixelCount);
   localparam int QueueDepth = 2;
   localparam int QueuePtrBits = $clog2(QueueDepth);

   typedef logic [15:0]          color_type;
   typedef logic [31:0]          index_word_type;
   typedef logic [PixelBits-1:0] pixel_num_type;
   typedef logic [7:0]           channel_type;

   // Decoded sub-block: four-entry palette plus the raw index word.
   typedef struct packed {
      color_type [3:0] palette;
      index_word_type  index_bits;
   } block_type;

endpackage
`default_nettype wire

### rtl/dbcd_front.sv
// Front end: accepts a compressed sub-block and builds its four-color palette.
// Depends on dbcd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dbcd_front (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire dbcd_pkg::color_type      req_first_color,
   input  wire dbcd_pkg::color_type      req_second_color,
   input  wire dbcd_pkg::index_word_type req_index_bits,
   output logic                         blk_valid,
   output dbcd_pkg::block_type           blk_data,
   input  wire logic                    blk_ready
);
   import dbcd_pkg::*;

   // x / 3 for x up to 189, via multiply by reciprocal 171/512.
   function automatic logic [5:0] div3(input logic [7:0] x);
      logic [16:0] prod;
      prod = 17'(x) * 17'd171;
      return prod[14:9];
   endfunction

   logic       valid_ff, valid_in;
   block_type  block_ff, block_in;
   logic       accept;
   logic       greater;
   logic [4:0] r0, r1, b0, b1;
   logic [5:0] g0, g1;
   logic [5:0] a_r, a_g, a_b, b_r, b_g, b_b;
   color_type  mix_a, mix_b;

   assign req_stall = valid_ff && !blk_ready;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      r0 = req_first_color[15:11];
      g0 = req_first_color[10:5];
      b0 = req_first_color[4:0];
      r1 = req_second_color[15:11];
      g1 = req_second_color[10:5];
      b1 = req_second_color[4:0];
      a_r = div3({2'b0, r0, 1'b0} + 8'(r1));
      a_g = div3({1'b0, g0, 1'b0} + 8'(g1));
      a_b = div3({2'b0, b0, 1'b0} + 8'(b1));
      b_r = div3(8'(r0) + {2'b0, r1, 1'b0});
      b_g = div3(8'(g0) + {1'b0, g1, 1'b0});
      b_b = div3(8'(b0) + {2'b0, b1, 1'b0});
      greater = req_first_color > req_second_color;
      if (greater) begin
         mix_a = {a_r[4:0], a_g, a_b[4:0]};
         mix_b = {b_r[4:0], b_g, b_b[4:0]};
      end else begin
         mix_a = {5'((6'(r0) + 6'(r1)) >> 1),
                  6'((7'(g0) + 7'(g1)) >> 1),
                  5'((6'(b0) + 6'(b1)) >> 1)};
         mix_b = '0;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      block_in = block_ff;
      if (accept) begin
         valid_in = 1'b1;
         block_in.palette    = {mix_b, mix_a, req_second_color, req_first_color};
         block_in.index_bits = req_index_bits;
      end else if (blk_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      block_ff <= block_in;
   end

   assign blk_valid = valid_ff;
   assign blk_data  = block_ff;

endmodule
`default_nettype wire

### rtl/dbcd_queue.sv
// Two-entry queue of decoded sub-blocks between front and back ends.
// Depends on dbcd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dbcd_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push_valid,
   output logic                     push_ready,
   input  wire dbcd_pkg::block_type push_data,
   output logic                     pop_valid,
   input  wire logic                pop,
   output dbcd_pkg::block_type      pop_data
);
   import dbcd_pkg::*;

   localparam int CountBits = $clog2(QueueDepth + 1);

   block_type                entry_ff [QueueDepth];
   logic [QueuePtrBits-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrBits-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CountBits-1:0]     count_ff, count_in;
   logic                     do_push, do_pop;

   assign push_ready = count_ff != CountBits'(QueueDepth);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QueuePtrBits'(QueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QueuePtrBits'(QueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

### rtl/dbcd_back.sv
// Back end: walks the sixteen indices of a decoded sub-block into a registered
// response stage, one pixel per cycle unless rsp_stall holds it. Depends on dbcd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dbcd_back (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   blk_valid,
   output logic                        blk_pop,
   input  wire dbcd_pkg::block_type    blk_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output dbcd_pkg::pixel_num_type     rsp_pixel_number,
   output dbcd_pkg::channel_type       rsp_red,
   output dbcd_pkg::channel_type       rsp_green,
   output dbcd_pkg::channel_type       rsp_blue,
   output logic                        rsp_last_pixel
);
   import dbcd_pkg::*;

   logic            busy_ff, busy_in;
   pixel_num_type   cnt_ff, cnt_in;
   color_type [3:0] pal_ff, pal_in;
   index_word_type  idx_ff, idx_in;
   logic            out_valid_ff, out_valid_in;
   pixel_num_type   out_num_ff, out_num_in;
   channel_type     out_r_ff, out_r_in, out_g_ff, out_g_in, out_b_ff, out_b_in;
   logic            out_last_ff, out_last_in;
   logic            advance, emit, done;
   color_type       raw;

   assign advance = !out_valid_ff || !rsp_stall;
   assign emit    = advance && busy_ff;
   assign done    = emit && (cnt_ff == pixel_num_type'(PixelCount - 1));
   assign blk_pop = blk_valid && (!busy_ff || done);
   assign raw     = pal_ff[idx_ff[31:30]];

   always_comb begin
      busy_in      = busy_ff;
      cnt_in       = cnt_ff;
      pal_in       = pal_ff;
      idx_in       = idx_ff;
      out_valid_in = out_valid_ff;
      out_num_in   = out_num_ff;
      out_r_in     = out_r_ff;
      out_g_in     = out_g_ff;
      out_b_in     = out_b_ff;
      out_last_in  = out_last_ff;
      if (advance) begin
         out_valid_in = busy_ff;
      end
      if (emit) begin
         out_num_in  = cnt_ff;
         out_r_in    = {raw[15:11], 3'b000};
         out_g_in    = {raw[10:6], 3'b000};
         out_b_in    = {raw[4:0], 3'b000};
         out_last_in = cnt_ff == pixel_num_type'(PixelCount - 1);
         cnt_in      = cnt_ff + 1'b1;
         idx_in      = {idx_ff[29:0], 2'b00};
         if (done) begin
            busy_in = 1'b0;
         end
      end
      if (blk_pop) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         pal_in  = blk_data.palette;
         idx_in  = blk_data.index_bits;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
      pal_ff      <= pal_in;
      idx_ff      <= idx_in;
      out_num_ff  <= out_num_in;
      out_r_ff    <= out_r_in;
      out_g_ff    <= out_g_in;
      out_b_ff    <= out_b_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_pixel_number = out_num_ff;
   assign rsp_red          = out_r_ff;
   assign rsp_green        = out_g_ff;
   assign rsp_blue         = out_b_ff;
   assign rsp_last_pixel   = out_last_ff;

endmodule
`default_nettype wire

### rtl/dxt_block_color_decoder_unit.sv
// BC1 (DXT1) 4x4 color sub-block decoder, top level.
// Instantiates dbcd_front, dbcd_queue and dbcd_back; depends on dbcd_pkg.
`timescale 1ns / 1ps
`default_nettype none
// Each request carries one compressed sub-block and yields sixteen pixel
// responses in raster order, one per cycle while rsp_stall is low, with
// last_pixel set on the sixteenth; the back-end pixel sequencer sets the
// sustained request rate. A request is registered in the front end, a queue
// entry and the back end before its first pixel. A two-entry queue behind the
// palette stage lets new requests be taken while the previous one streams out.
module dxt_block_color_decoder_unit (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire dbcd_pkg::color_type      req_first_color,
   input  wire dbcd_pkg::color_type      req_second_color,
   input  wire dbcd_pkg::index_word_type req_index_bits,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output dbcd_pkg::pixel_num_type       rsp_pixel_number,
   output dbcd_pkg::channel_type         rsp_red,
   output dbcd_pkg::channel_type         rsp_green,
   output dbcd_pkg::channel_type         rsp_blue,
   output logic                         rsp_last_pixel
);
   import dbcd_pkg::*;

   logic      front_valid, front_ready;
   block_type front_data;
   logic      q_valid, q_pop;
   block_type q_data;

   dbcd_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_first_color  (req_first_color),
      .req_second_color (req_second_color),
      .req_index_bits   (req_index_bits),
      .blk_valid        (front_valid),
      .blk_data         (front_data),
      .blk_ready        (front_ready)
   );

   dbcd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_data  (front_data),
      .pop_valid  (q_valid),
      .pop        (q_pop),
      .pop_data   (q_data)
   );

   dbcd_back u_back (
      .clock            (clock),
      .reset            (reset),
      .blk_valid        (q_valid),
      .blk_pop          (q_pop),
      .blk_data         (q_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pixel_number (rsp_pixel_number),
      .rsp_red          (rsp_red),
      .rsp_green        (rsp_green),
      .rsp_blue         (rsp_blue),
      .rsp_last_pixel   (rsp_last_pixel)
   );

endmodule
`default_nettype wire
